// ----- rtl/tir_pkg.sv -----
// Package with shared types and codes for the table interpolated responsivity block.
package tir_pkg;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_APPEND  = 2'd1;
    localparam logic [1:0] OP_MEASURE = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LO_RD,
        S_HI_RD,
        S_MUL1,
        S_DIV1,
        S_INTERP,
        S_MUL2,
        S_DIV2,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic do_append;
        logic do_clear;
        logic rd_scan;
        logic scan_inc;
        logic rd_lo;
        logic rd_hi;
        logic mul1;
        logic div1_start;
        logic interp_ld;
        logic mul2;
        logic div2_start;
        logic emit;
        logic [1:0] emit_status;
    } tir_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_lt2;
        logic scan_end;
        logic scan_ge;
        logic scan_eq;
        logic scan_first;
        logic dw_zero;
        logic cal_zero;
        logic div_busy;
    } tir_stat_t;

endpackage

// ----- rtl/table_interpolated_responsivity.sv -----
// Top level of the table interpolated responsivity block.
//
// Usage: drive op and the payload ports with start high while busy is low; the
// request is taken at that clock edge. A clear or append request completes in
// that cycle, gives no result and leaves busy low, so the next request can be
// taken at the following edge. A measure request scans the reference table
// from entry zero through read and check states, reads the bracketing pair,
// then runs two 64-step serial divisions in one shared divider (segment
// interpolation, then sample times reference over calibration).
// Out-of-table wavelengths end after the scan, without the divisions. The
// result appears on responsivity, wavelength_echo and status with done high
// for one cycle; the receiver cannot stall, so the result is simply
// presented once. The next request can be taken in the cycle after done.
// Reset empties the table (fill count zero) and returns the controller to
// idle; table contents are undefined until appended.
module table_interpolated_responsivity #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [23:0]        wavelength,
    input  logic signed [31:0] ref_value,
    input  logic signed [31:0] cal_reading,
    input  logic signed [31:0] sample_reading,
    output logic               done,
    output logic signed [31:0] responsivity,
    output logic [23:0]        wavelength_echo,
    output logic [1:0]         status
);
    import tir_pkg::*;

    tir_cmd_t  cmd;
    tir_stat_t stat;
    logic      ctrl_busy;

    tir_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy)
    );

    tir_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .wavelength      (wavelength),
        .ref_value       (ref_value),
        .cal_reading     (cal_reading),
        .sample_reading  (sample_reading),
        .done            (done),
        .responsivity    (responsivity),
        .wavelength_echo (wavelength_echo),
        .status          (status)
    );

    assign busy = ctrl_busy;
endmodule

// ----- rtl/tir_div.sv -----
// Serial restoring divider for signed operands, truncating toward zero.
module tir_div #(
    parameter int W = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] dividend,
    input  logic signed [W-1:0] divisor,
    output logic                busy,
    output logic signed [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;
    logic [W:0]    sub;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[W-1]};
        sub       = trial - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend[W-1] ? -dividend : dividend;
            d_next    = divisor[W-1] ? -divisor : divisor;
            r_next    = '0;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!sub[W])
            begin
                r_next = sub[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg | start;
    assign quotient = neg_reg ? -q_reg : q_reg;
endmodule

// ----- rtl/tir_datapath.sv -----
// Datapath: reference table memory, scan index, interpolation and ratio arithmetic.
module tir_datapath #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tir_pkg::tir_cmd_t     cmd,
    output tir_pkg::tir_stat_t    stat,
    input  logic [23:0]           wavelength,
    input  logic signed [31:0]    ref_value,
    input  logic signed [31:0]    cal_reading,
    input  logic signed [31:0]    sample_reading,
    output logic                  done,
    output logic signed [31:0]    responsivity,
    output logic [23:0]           wavelength_echo,
    output logic [1:0]            status
);
    import tir_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(TABLE_DEPTH + 1);

    logic [23:0] wl_mem [TABLE_DEPTH];
    logic [31:0] rv_mem [TABLE_DEPTH];

    logic [FW-1:0]      fill_reg;
    logic [FW-1:0]      idx_reg;
    logic [23:0]        x_reg;
    logic signed [31:0] cal_reg, smp_reg;
    logic [23:0]        rd_wl_reg;
    logic [31:0]        rd_rv_reg;
    logic [23:0]        w0_reg;
    logic signed [31:0] v0_reg;
    logic signed [25:0] dw_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] interp_reg;
    logic               done_reg;
    logic signed [31:0] resp_reg;
    logic [1:0]         status_reg;
    logic [AW-1:0]      rd_addr;
    logic signed [63:0] div_a, div_b, div_q;
    logic               div_start, div_busy;
    logic signed [32:0] dv;
    logic signed [25:0] dx;
    logic signed [31:0] interp32;

    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        if (cmd.rd_lo)
            rd_addr = AW'(idx_reg - 1'b1);
        else if (cmd.rd_hi && stat.scan_first)
            // For segment zero the high point is entry one.
            rd_addr = AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_append && fill_reg < FW'(TABLE_DEPTH))
        begin
            wl_mem[fill_reg[AW-1:0]] <= wavelength;
            rv_mem[fill_reg[AW-1:0]] <= ref_value;
        end
        rd_wl_reg <= wl_mem[rd_addr];
        rd_rv_reg <= rv_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.do_clear)
                fill_reg <= '0;
            else if (cmd.do_append && fill_reg < FW'(TABLE_DEPTH))
                fill_reg <= fill_reg + 1'b1;
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.scan_inc)
                idx_reg <= idx_reg + 1'b1;
            else if (cmd.rd_hi && stat.scan_first)
                idx_reg <= FW'(1);
        end
    end

    assign dv = 33'(signed'(rd_rv_reg)) - 33'(v0_reg);
    assign dx = 26'(signed'({2'b0, x_reg})) - 26'(signed'({2'b0, w0_reg}));
    assign interp32 = interp_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= wavelength;
            cal_reg <= cal_reading;
            smp_reg <= sample_reading;
        end
        if (cmd.rd_hi)
        begin
            w0_reg <= rd_wl_reg;
            v0_reg <= rd_rv_reg;
        end
        if (cmd.mul1)
        begin
            dw_reg   <= 26'(signed'({2'b0, rd_wl_reg})) - 26'(signed'({2'b0, w0_reg}));
            prod_reg <= 64'(dv * dx);
        end
        if (cmd.interp_ld)
            interp_reg <= 64'(v0_reg) + div_q;
        if (cmd.mul2)
            prod_reg <= 64'(smp_reg * interp32);
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_status;
            if (cmd.emit_status != ST_OK)
                resp_reg <= '0;
            else if (div_q > 64'sd2147483647)
                resp_reg <= 32'sh7fffffff;
            else if (div_q < -64'sd2147483648)
                resp_reg <= 32'sh80000000;
            else
                resp_reg <= div_q[31:0];
        end
    end

    always_comb
    begin
        div_start = cmd.div1_start | cmd.div2_start;
        div_a     = prod_reg;
        div_b     = cmd.div2_start ? 64'(cal_reg) : 64'(dw_reg);
    end

    tir_div #(.W(64)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        stat.fill_lt2   = fill_reg < FW'(2);
        stat.scan_end   = idx_reg >= fill_reg;
        stat.scan_ge    = rd_wl_reg >= x_reg;
        stat.scan_eq    = rd_wl_reg == x_reg;
        stat.scan_first = idx_reg == '0;
        stat.dw_zero    = dw_reg == '0;
        stat.cal_zero   = cal_reg == '0;
        stat.div_busy   = div_busy;
    end

    assign done            = done_reg;
    assign responsivity    = resp_reg;
    assign wavelength_echo = x_reg;
    assign status          = status_reg;
endmodule

// ----- rtl/tir_ctrl.sv -----
// Controller state machine that sequences the scan, reads, multiplies and divisions.
module tir_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    input  tir_pkg::tir_stat_t stat,
    output tir_pkg::tir_cmd_t  cmd,
    output logic               busy
);
    import tir_pkg::*;

    state_t state_reg, state_next;
    logic   seen_reg, seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        cmd        = '0;
        busy       = state_reg != S_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_CLEAR:   cmd.do_clear = 1'b1;
                        OP_APPEND:  cmd.do_append = 1'b1;
                        OP_MEASURE:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_SCAN_RD;
                        end
                        default:    ;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (stat.fill_lt2 || stat.scan_end)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (stat.scan_ge)
                begin
                    if (stat.scan_first && !stat.scan_eq)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // For segment zero the low point is entry zero itself.
                        seen_next  = stat.scan_first;
                        cmd.rd_lo  = !stat.scan_first;
                        state_next = S_LO_RD;
                    end
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_LO_RD:
            begin
                // The read data now holds the low point; latch it and read the high point.
                cmd.rd_hi  = 1'b1;
                state_next = S_HI_RD;
            end
            S_HI_RD:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                if (stat.dw_zero)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_DIV0;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.div1_start = 1'b1;
                    state_next     = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (!stat.div_busy)
                begin
                    if (stat.cal_zero)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_DIV0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cmd.interp_ld = 1'b1;
                        state_next    = S_INTERP;
                    end
                end
            end
            S_INTERP:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.div2_start = 1'b1;
                state_next     = S_DIV2;
            end
            S_DIV2:
            begin
                if (!stat.div_busy)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                seen_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (seen_reg && state_reg == S_LO_RD)
            cmd.rd_hi = 1'b1;
    end
endmodule
